>>> sv/gcd_pkg.sv
// shared constants and types for the great circle distance pipeline
package gcd_pkg;

  localparam int unsigned ANGLE_FRAC_BITS = 22;

  // angle to turn conversion: q = (m * 2^(29-F) + 22) / 45
  localparam int unsigned TURN_SHL   = 29 - ANGLE_FRAC_BITS;
  localparam logic [5:0]  TURN_DIV   = 6'd45;
  localparam logic [5:0]  TURN_BIAS  = 6'd22;

  // floor(m / 45) = (m * (2^32 + RECIP_LO)) >> 38 for any 32-bit m
  localparam logic [30:0] RECIP_LO    = 31'd1813430637;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned QUO_W       = 26;
  // remainder part: floor(x / 45) = (x * FRAC_RECIP) >> FRAC_K for x below 45 * 2^TURN_SHL + 22
  localparam int unsigned FRAC_K      = TURN_SHL + 12;
  localparam logic [20:0] FRAC_RECIP  = 21'(((64'd1 << FRAC_K) + 64'd44) / 64'd45);

  localparam int unsigned CW           = 34;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned SQ_W         = 62;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t CORDIC_START = 34'sd652032874;
  localparam cw_t Q30_ONE      = 34'sd1073741824;
  localparam cw_t HALF_TURN    = 34'sd2147483648;

  localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43,
    30'h0145D7E1, 30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F,
    30'h000A2F98, 30'h000517CC, 30'h00028BE6, 30'h000145F3, 30'h0000A2FA,
    30'h0000517D, 30'h000028BE, 30'h0000145F, 30'h00000A30, 30'h00000518,
    30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051, 30'h00000029,
    30'h00000014, 30'h0000000A, 30'h00000005, 30'h00000003, 30'h00000001
  };

  localparam logic [32:0] METER_SCALE = 33'd5123615706;
  localparam logic [28:0] DIST_MAX    = 29'd320226000;

endpackage

>>> sv/gcd_turn.sv
// pipelined conversion of a signed angle to a 32-bit binary angle
module gcd_turn import gcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic signed [31:0] ang_i,
  output logic              vld_o,
  output logic [31:0]       turn_o
);

  logic [31:0]         mag;
  logic [64:0]         full;
  logic [31:0]         quo45;
  logic [19:0]         fx;
  logic [40:0]         fprod;
  logic [31:0]         qlo;

  logic [5:0]          vld_q;
  logic [4:0]          neg_q;
  logic [31:0]         mag_a_q, mag_b_q, mag_c_q;
  logic [62:0]         prod_q;
  logic [QUO_W-1:0]    quo_c_q, quo_d_q, quo_e_q;
  logic [5:0]          rem_q;
  logic [TURN_SHL-1:0] frac_q;
  logic [31:0]         turn_q;

  assign mag   = ang_i[31] ? 32'(-ang_i) : 32'(ang_i);
  // magnitude over 45 by reciprocal, the top part of the reciprocal is 2^32
  assign full  = {1'b0, mag_b_q, 32'b0} + 65'(prod_q);
  assign quo45 = 32'(quo_c_q) * 32'(TURN_DIV);
  // low quotient bits come from the remainder alone
  assign fx    = (20'(rem_q) << TURN_SHL) + 20'(TURN_BIAS);
  assign fprod = 41'(fx) * 41'(FRAC_RECIP);
  assign qlo   = 32'({quo_e_q, frac_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_a_q <= mag;
      neg_q   <= {neg_q[3:0], ang_i[31]};
      prod_q  <= 63'(mag_a_q) * 63'(RECIP_LO);
      mag_b_q <= mag_a_q;
      quo_c_q <= full[RECIP_SHIFT +: QUO_W];
      mag_c_q <= mag_b_q;
      rem_q   <= 6'(mag_c_q - quo45);
      quo_d_q <= quo_c_q;
      frac_q  <= fprod[FRAC_K +: TURN_SHL];
      quo_e_q <= quo_d_q;
      turn_q  <= neg_q[4] ? -qlo : qlo;
    end
  end

  assign vld_o  = vld_q[5];
  assign turn_o = turn_q;

endmodule

>>> sv/gcd_sincos.sv
// pipelined rotation cordic giving cosine and sine of a binary angle
module gcd_sincos import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        vld_i,
  input  logic [31:0] turn_i,
  output logic        vld_o,
  output cw_t         cos_o,
  output cw_t         sin_o
);

  cw_t        x_q [CORDIC_STEPS+1];
  cw_t        y_q [CORDIC_STEPS+1];
  cw_t        z_q [CORDIC_STEPS+1];
  logic [1:0] quad_q [CORDIC_STEPS+1];
  logic       vld_q [CORDIC_STEPS+1];
  cw_t        cos_q;
  cw_t        sin_q;
  logic       vldo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_START;
      y_q[0]    <= '0;
      z_q[0]    <= $signed({{(CW-30){1'b0}}, turn_i[29:0]});
      quad_q[0] <= turn_i[31:30];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    cw_t dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({{(CW-30){1'b0}}, ATAN_TURN[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        quad_q[i+1] <= quad_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldo_q <= 1'b0;
    end else if (en_i) begin
      vldo_q <= vld_q[CORDIC_STEPS];
    end
  end

  // quadrant fold
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      case (quad_q[CORDIC_STEPS])
        2'd0: begin
          cos_q <= x_q[CORDIC_STEPS];
          sin_q <= y_q[CORDIC_STEPS];
        end
        2'd1: begin
          cos_q <= -y_q[CORDIC_STEPS];
          sin_q <= x_q[CORDIC_STEPS];
        end
        2'd2: begin
          cos_q <= -x_q[CORDIC_STEPS];
          sin_q <= -y_q[CORDIC_STEPS];
        end
        default: begin
          cos_q <= y_q[CORDIC_STEPS];
          sin_q <= -x_q[CORDIC_STEPS];
        end
      endcase
    end
  end

  assign vld_o = vldo_q;
  assign cos_o = cos_q;
  assign sin_o = sin_q;

endmodule

>>> sv/gcd_sum.sv
// cosine sum of the law of cosines with rounding and clamp to [-1, 1]
module gcd_sum import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  cw_t                cos1_i,
  input  cw_t                sin1_i,
  input  cw_t                cos2_i,
  input  cw_t                sin2_i,
  input  cw_t                cosd_i,
  output logic               vld_o,
  output logic signed [31:0] sum_o
);

  localparam logic signed [67:0] RND = 68'sd536870912;

  logic signed [67:0] ss_q, cc_q, ccd_q;
  cw_t                cd1_q, cd2_q, ssr_q, ssr2_q, ccr_q;
  logic signed [31:0] sum_q;
  logic [3:0]         vld_q;
  logic signed [67:0] ss_rnd, cc_rnd, ccd_rnd;
  logic signed [CW:0] tot;

  assign ss_rnd  = (ss_q + RND) >>> 30;
  assign cc_rnd  = (cc_q + RND) >>> 30;
  assign ccd_rnd = (ccd_q + RND) >>> 30;
  assign tot     = (CW+1)'(ssr2_q) + (CW+1)'(ccd_rnd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ss_q   <= 68'(sin1_i) * 68'(sin2_i);
      cc_q   <= 68'(cos1_i) * 68'(cos2_i);
      cd1_q  <= cosd_i;
      ssr_q  <= CW'(ss_rnd);
      ccr_q  <= CW'(cc_rnd);
      cd2_q  <= cd1_q;
      ccd_q  <= 68'(ccr_q) * 68'(cd2_q);
      ssr2_q <= ssr_q;
      if (tot > (CW+1)'(Q30_ONE)) begin
        sum_q <= 32'(Q30_ONE);
      end else if (tot < -(CW+1)'(Q30_ONE)) begin
        sum_q <= 32'(-Q30_ONE);
      end else begin
        sum_q <= 32'(tot);
      end
    end
  end

  assign vld_o = vld_q[3];
  assign sum_o = sum_q;

endmodule

>>> sv/gcd_acos.sv
// arccosine of the cosine sum: square root then vectoring cordic
module gcd_acos import gcd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic signed [31:0] sum_i,
  output logic               vld_o,
  output logic [31:0]        ang_o
);

  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 60;

  logic [SQ_W-1:0]    sq_q;
  logic signed [31:0] s0_q;
  logic [1:0]         vpre_q;

  logic [SQ_W-1:0]    v_q [SQRT_STEPS+1];
  logic [SQ_W-1:0]    r_q [SQRT_STEPS+1];
  logic signed [31:0] s_q [SQRT_STEPS+1];
  logic               vs_q [SQRT_STEPS+1];

  cw_t  x_q [CORDIC_STEPS+1];
  cw_t  y_q [CORDIC_STEPS+1];
  cw_t  z_q [CORDIC_STEPS+1];
  logic vc_q [CORDIC_STEPS+1];

  logic [31:0] ang_q;
  logic        vldo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vpre_q <= '0;
    end else if (en_i) begin
      vpre_q <= {vpre_q[0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= SQ_W'(64'(sum_i) * 64'(sum_i));
      s0_q <= sum_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= ONE_SQ - sq_q;
      r_q[0] <= '0;
      s_q[0] <= s0_q;
    end
  end
  assign vs_q[0] = vpre_q[1];

  // integer square root, one result bit per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] B = SQ_W'(1) << (60 - 2*k);
    logic [SQ_W-1:0] rb;
    assign rb = r_q[k] + B;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vs_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vs_q[k+1] <= vs_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (v_q[k] >= rb) begin
          v_q[k+1] <= v_q[k] - rb;
          r_q[k+1] <= (r_q[k] >> 1) + B;
        end else begin
          v_q[k+1] <= v_q[k];
          r_q[k+1] <= r_q[k] >> 1;
        end
        s_q[k+1] <= s_q[k];
      end
    end
  end

  // quarter turn pre-rotation for a negative sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q[0] <= 1'b0;
    end else if (en_i) begin
      vc_q[0] <= vs_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (s_q[SQRT_STEPS][31]) begin
        x_q[0] <= CW'(r_q[SQRT_STEPS]);
        y_q[0] <= -CW'(s_q[SQRT_STEPS]);
        z_q[0] <= Q30_ONE;
      end else begin
        x_q[0] <= CW'(s_q[SQRT_STEPS]);
        y_q[0] <= CW'(r_q[SQRT_STEPS]);
        z_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec
    cw_t dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = $signed({{(CW-30){1'b0}}, ATAN_TURN[i]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vc_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vc_q[i+1] <= vc_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end else begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldo_q <= 1'b0;
    end else if (en_i) begin
      vldo_q <= vc_q[CORDIC_STEPS];
    end
  end

  // clamp to [0, half turn]
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (z_q[CORDIC_STEPS][CW-1]) begin
        ang_q <= '0;
      end else if (z_q[CORDIC_STEPS] > HALF_TURN) begin
        ang_q <= 32'(HALF_TURN);
      end else begin
        ang_q <= 32'(z_q[CORDIC_STEPS]);
      end
    end
  end

  assign vld_o = vldo_q;
  assign ang_o = ang_q;

endmodule

>>> sv/great_circle_distance_top.sv
// top level: great circle distance between two positions, pipelined
// Takes one pair of positions per cycle while not stalled (latitude and longitude in
// signed units of 2^-22 degree) and returns the distance in sixteenths of a meter,
// saturating at 320226000. Items leave in order and pass through the reciprocal
// conversion to binary angle, the sine and cosine cordic, the cosine sum, the 31-stage
// square root and the 30-stage arccosine cordic and the scaling to meters. A stall on
// the output holds the whole pipeline in place.
module great_circle_distance_top import gcd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [29:0] first_latitude_i,
  input  logic [30:0] first_longitude_i,
  input  logic [29:0] second_latitude_i,
  input  logic [30:0] second_longitude_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [28:0] distance_sixteenths_o
);

  logic               en;
  logic signed [31:0] lat1, lat2, dlon;
  logic               vt1, vt2, vtd, vs1, vs2, vsd, vsum, vang;
  logic [31:0]        t1, t2, td, ang;
  cw_t                c1, s1, c2, s2, cd, sd;
  logic signed [31:0] sum;

  logic [49:0]        lo_q;
  logic [47:0]        hi_q;
  logic               vp_q;
  logic [28:0]        dist_q;
  logic               vout_q;
  logic [65:0]        dfull;
  logic [30:0]        dsh;
  logic               sd_unused;

  assign stall_o = vout_q & stall_i;
  assign en      = ~stall_o;

  assign lat1 = 32'(signed'(first_latitude_i));
  assign lat2 = 32'(signed'(second_latitude_i));
  assign dlon = 32'(signed'(first_longitude_i)) - 32'(signed'(second_longitude_i));

  gcd_turn u_turn_lat1 (.clk_i, .rst_ni, .en_i(en), .vld_i(valid_i), .ang_i(lat1),
                        .vld_o(vt1), .turn_o(t1));
  gcd_turn u_turn_lat2 (.clk_i, .rst_ni, .en_i(en), .vld_i(valid_i), .ang_i(lat2),
                        .vld_o(vt2), .turn_o(t2));
  gcd_turn u_turn_dlon (.clk_i, .rst_ni, .en_i(en), .vld_i(valid_i), .ang_i(dlon),
                        .vld_o(vtd), .turn_o(td));

  gcd_sincos u_sc_lat1 (.clk_i, .rst_ni, .en_i(en), .vld_i(vt1), .turn_i(t1),
                        .vld_o(vs1), .cos_o(c1), .sin_o(s1));
  gcd_sincos u_sc_lat2 (.clk_i, .rst_ni, .en_i(en), .vld_i(vt2), .turn_i(t2),
                        .vld_o(vs2), .cos_o(c2), .sin_o(s2));
  gcd_sincos u_sc_dlon (.clk_i, .rst_ni, .en_i(en), .vld_i(vtd), .turn_i(td),
                        .vld_o(vsd), .cos_o(cd), .sin_o(sd));

  // the longitude sine is not needed
  assign sd_unused = ^sd;

  gcd_sum u_sum (.clk_i, .rst_ni, .en_i(en), .vld_i(vs1 & vs2 & vsd),
                 .cos1_i(c1), .sin1_i(s1), .cos2_i(c2), .sin2_i(s2), .cosd_i(cd),
                 .vld_o(vsum), .sum_o(sum));

  gcd_acos u_acos (.clk_i, .rst_ni, .en_i(en), .vld_i(vsum), .sum_i(sum),
                   .vld_o(vang), .ang_o(ang));

  // meters per turn split into two partial products
  assign dfull = {hi_q, 17'b0} + 66'(lo_q) + (66'(1) << 34);
  assign dsh   = 31'(dfull >> 35);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q   <= 1'b0;
      vout_q <= 1'b0;
    end else if (en) begin
      vp_q   <= vang;
      vout_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lo_q <= 50'(ang) * 50'(METER_SCALE[16:0]);
      hi_q <= 48'(ang) * 48'(METER_SCALE[32:17]);
      if (dsh > 31'(DIST_MAX) || sd_unused & 1'b0) begin
        dist_q <= DIST_MAX;
      end else begin
        dist_q <= dsh[28:0];
      end
    end
  end

  assign valid_o               = vout_q;
  assign distance_sixteenths_o = dist_q;

endmodule

>>> tb/tb_great_circle_distance_top.sv
// testbench for the great circle distance pipeline with a built-in distance predictor
`timescale 1ns / 100ps

module tb_great_circle_distance_top import gcd_pkg::*; ();

  localparam int unsigned PIPE_LATENCY = 109;
  localparam int unsigned EXP_DEPTH    = 1024;
  localparam longint LAT_MAX = 64'sd377487360;
  localparam longint LON_MAX = 64'sd754974720;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [29:0] first_latitude_i;
  logic [30:0] first_longitude_i;
  logic [29:0] second_latitude_i;
  logic [30:0] second_longitude_i;
  logic        valid_o;
  logic        stall_i;
  logic [28:0] distance_sixteenths_o;

  logic [28:0] expected_mem [EXP_DEPTH];
  int          sent_count;
  int          checked_count;
  int          mismatch_count;
  int          stall_left;
  bit          sink_idle;

  great_circle_distance_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .valid_i               (valid_i),
    .stall_o               (stall_o),
    .first_latitude_i      (first_latitude_i),
    .first_longitude_i     (first_longitude_i),
    .second_latitude_i     (second_latitude_i),
    .second_longitude_i    (second_longitude_i),
    .valid_o               (valid_o),
    .stall_i               (stall_i),
    .distance_sixteenths_o (distance_sixteenths_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint floor_shift(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint table_angle(int i);
    return longint'(ATAN_TURN[i]);
  endfunction

  // degrees in 2^-F units to binary angle, rounded half away from zero
  function automatic logic [31:0] deg_to_turn(longint v);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << (32 - ANGLE_FRAC_BITS)) + 180) / 360;
    if (v < 0) q = -q;
    return q[31:0];
  endfunction

  function automatic void rotate_turn(input logic [31:0] a, output longint cos_v,
                                      output longint sin_v);
    longint x, y, z, dx, dy;
    x = CORDIC_START;
    y = 0;
    z = longint'(a[29:0]);
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= table_angle(i);
      end else begin
        x += dx; y -= dy; z += table_angle(i);
      end
    end
    case (a[31:30])
      2'd0: begin cos_v = x;  sin_v = y;  end
      2'd1: begin cos_v = -y; sin_v = x;  end
      2'd2: begin cos_v = -x; sin_v = -y; end
      default: begin cos_v = y; sin_v = -x; end
    endcase
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return floor_shift(a * b + (64'sd1 <<< 29), 30);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint arccos_turn(longint s);
    longint one, x, y, z, t, dx, dy;
    one = 64'sd1 <<< 30;
    x = s;
    z = 0;
    y = longint'(int_sqrt(longint'(one * one - s * s)));
    if (x < 0) begin
      t = x; x = y; y = -t; z = one;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += table_angle(i);
      end else begin
        x -= dx; y += dy; z -= table_angle(i);
      end
    end
    if (z < 0) z = 0;
    if (z > 2 * one) z = 2 * one;
    return z;
  endfunction

  function automatic logic [28:0] predict_distance(logic [29:0] lat1, logic [30:0] lon1,
                                                   logic [29:0] lat2, logic [30:0] lon2);
    longint c1, s1, c2, s2, cd, sd, cos_sum, ang, one;
    longint unsigned result_v;
    one = 64'sd1 <<< 30;
    rotate_turn(deg_to_turn(longint'($signed(lat1))), c1, s1);
    rotate_turn(deg_to_turn(longint'($signed(lat2))), c2, s2);
    rotate_turn(deg_to_turn(longint'($signed(lon1)) - longint'($signed(lon2))), cd, sd);
    cos_sum = q30_mul(s1, s2) + q30_mul(q30_mul(c1, c2), cd);
    if (cos_sum > one) cos_sum = one;
    if (cos_sum < -one) cos_sum = -one;
    ang = arccos_turn(cos_sum);
    result_v = (longint'(ang) * longint'(METER_SCALE) + (64'd1 << 34)) >> 35;
    if (result_v > DIST_MAX) result_v = DIST_MAX;
    return result_v[28:0];
  endfunction

  // ---------------- driving and checking ----------------
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(5, 40);
    return $urandom_range(0, 2);
  endfunction

  task automatic report_mismatch(input string what, input logic [28:0] got,
                                 input logic [28:0] want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_pair(input longint lat1, input longint lon1,
                           input longint lat2, input longint lon2, input bit use_gaps);
    logic [29:0] a;
    logic [30:0] b;
    logic [29:0] c;
    logic [30:0] d;
    int gap;
    a = lat1[29:0]; b = lon1[30:0]; c = lat2[29:0]; d = lon2[30:0];
    expected_mem[sent_count] = predict_distance(a, b, c, d);
    sent_count++;
    valid_i            <= 1'b1;
    first_latitude_i   <= a;
    first_longitude_i  <= b;
    second_latitude_i  <= c;
    second_longitude_i <= d;
    do @(posedge clk_i); while (stall_o);
    gap = use_gaps ? gap_length() : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // any field value, with occasional values beyond the nominal ranges
  function automatic longint pick_lat();
    if ($urandom_range(0, 9) == 0) return longint'($signed(30'($urandom)));
    return longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX;
  endfunction

  function automatic longint pick_lon();
    if ($urandom_range(0, 9) == 0) return longint'($signed(31'($urandom)));
    return longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX;
  endfunction

  // output stalls come in runs, most of them short and a few long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_i    <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_i    <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (sink_idle && $urandom_range(0, 3) == 0) begin
      stall_i    <= 1'b1;
      stall_left <= gap_length();
    end else begin
      stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      if (checked_count >= sent_count) begin
        report_mismatch("unexpected distance", distance_sixteenths_o, '0);
      end else begin
        logic [28:0] want;
        want = expected_mem[checked_count];
        checked_count++;
        if (distance_sixteenths_o !== want)
          report_mismatch("distance_sixteenths", distance_sixteenths_o, want);
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_extremes();
    send_pair(0, 0, 0, 0, 0);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0, 0);
    send_pair(0, LON_MAX, 0, 0, 0);
    send_pair(0, -LON_MAX, 0, LON_MAX, 0);
    send_pair(0, 0, 0, 754974720 / 2, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX, 0);
    send_pair(-LAT_MAX, 123456, -LAT_MAX, -9876543, 0);
    send_pair(1, 0, 0, 0, 0);
    send_pair(0, 1, 0, 0, 1);
    send_pair(200000000, 300000000, 200000000, 300000001, 1);
  endtask

  task automatic test_out_of_range();
    // field limits of the port widths, past +-90 / +-180 degrees
    send_pair(-(64'sd1 <<< 29), -(64'sd1 <<< 30), (64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1, 1);
    send_pair((64'sd1 <<< 29) - 1, (64'sd1 <<< 30) - 1, -(64'sd1 <<< 29), -(64'sd1 <<< 30), 1);
    send_pair(500000000, -900000000, -500000000, 900000000, 1);
    send_pair(-1, -1, -1, -1, 1);
  endtask

  task automatic test_near_points();
    // cosine sum close to one and minus one: clamp and antipode cases
    longint lat, lon;
    for (int i = 0; i < 8; i++) begin
      lat = pick_lat();
      lon = pick_lon();
      send_pair(lat, lon, lat + $urandom_range(0, 3), lon - $urandom_range(0, 3), 1);
      send_pair(lat, lon, -lat, lon + ((lon > 0) ? -LON_MAX : LON_MAX), 1);
    end
  endtask

  task automatic test_random();
    for (int i = 0; i < 880; i++) begin
      sink_idle = (i % 200) < 150;
      send_pair(pick_lat(), pick_lon(), pick_lat(), pick_lon(), (i % 300) < 220);
    end
    sink_idle = 1'b1;
  endtask

  initial begin
    int waited;
    mismatch_count = 0;
    sent_count = 0;
    checked_count = 0;
    sink_idle = 1'b1;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    first_latitude_i = '0;
    first_longitude_i = '0;
    second_latitude_i = '0;
    second_longitude_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_out_of_range();
    test_near_points();
    test_random();
    valid_i <= 1'b0;
    waited = 0;
    while (checked_count != sent_count && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (PIPE_LATENCY + 20) @(posedge clk_i);
    if (checked_count != sent_count) begin
      report_mismatch("distances never arrived", 29'(sent_count - checked_count), '0);
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
